// ===== hdl/sst_pkg.sv =====
// ============================================================================
// sst_pkg
// Shared types, codes and defaults of the sorted station table.
// ============================================================================
package sst_pkg;

    // default geometry
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int NAME_BYTES_DEF  = 8;
    localparam int FREQ_W          = 32;

    // request codes
    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_DEL  = 2'd1;
    localparam logic [1:0] REQ_FIND = 2'd2;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_BADIDX   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // request beat
    typedef struct packed {
        logic [1:0]        req_type;
        logic [FREQ_W-1:0] freq_value;
        logic [63:0]       name_tag;
        logic [5:0]        entry_index;
    } req_t;

    // result beat
    typedef struct packed {
        status_t    status;
        logic [5:0] result_index;
        logic [6:0] entry_count;
    } rsp_t;

    // comparator flags: table entry against the search key
    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_t;

endpackage

// ===== hdl/sst_mem.sv =====
// ============================================================================
// sst_mem
// Entry store: one write port, one read port with registered read data.
// ============================================================================
module sst_mem
    import sst_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(TABLE_DEPTH_DEF),
    parameter int DW    = FREQ_W + 8 * NAME_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/sst_cmp.sv =====
// ============================================================================
// sst_cmp
// Shared frequency comparator used by the search and insert walks.
// ============================================================================
module sst_cmp
    import sst_pkg::*;
(
    input  logic [FREQ_W-1:0] entry_freq,
    input  logic [FREQ_W-1:0] key_freq,
    output cmp_t              res
);

    // equal / greater-than of the stored entry against the key
    always_comb
    begin
        res.eq = (entry_freq == key_freq);
        res.gt = (entry_freq > key_freq);
    end

endmodule

// ===== hdl/sorted_station_table_core.sv =====
// ============================================================================
// sorted_station_table_core
// Station table kept sorted by frequency: add, delete by slot, find.
// ============================================================================
// Usage:
//   A request beat (req) is taken at a rising edge with start high and busy
//   low. busy stays high while the request walks the table. Each request
//   gives exactly one result beat on rsp, marked by done for one cycle; the
//   receiver cannot hold it off, so it must sample rsp whenever done is high.
//   done rises at the finishing edge; busy is already low then,
//   so the next request may start in that cycle.
// Steps: a refused add (full), a bad delete index and an unused code are
//   answered from idle; find walks the entries up from slot 0; add walks
//   them too, then shifts the entries above the insert slot up; delete
//   shifts the entries above the deleted slot down.
//   The pace is set by the single read port of the entry store: the
//   sequencer reads one entry per cycle and feeds it through one shared
//   comparator, and the shift of entries moves one slot per cycle.
// Reset: the entry count clears at once; the entry store is not cleared,
//   since only slots below the count are ever read.
// ============================================================================
module sorted_station_table_core
    import sst_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = 8 * NAME_BYTES;
    localparam int DW = FREQ_W + NW;
    localparam int IW = (CW > 7) ? CW : 7;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DEL   = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic          pend_reg, pend_next;
    logic          done_reg, done_next;
    req_t          op_reg, op_next;
    rsp_t          rsp_reg, rsp_next;

    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [DW-1:0] mem_rd_data;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [DW-1:0] mem_wr_data;
    cmp_t          cmp_res;
    logic          hit;
    logic [CW-1:0] ptr_dec;

    // result beat builder: slot and count masked to field widths
    function automatic rsp_t make_rsp(status_t s, logic [CW-1:0] slot,
                                      logic [CW-1:0] cnt);
        rsp_t          r;
        logic [IW-1:0] slot_w;
        logic [IW-1:0] cnt_w;
        slot_w         = IW'(slot);
        cnt_w          = IW'(cnt);
        r.status       = s;
        r.result_index = slot_w[5:0];
        r.entry_count  = cnt_w[6:0];
        return r;
    endfunction

    // entry store: {name, freq}
    sst_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // shared comparator on the entry just read
    sst_cmp u_cmp (
        .entry_freq (mem_rd_data[FREQ_W-1:0]),
        .key_freq   (op_reg.freq_value),
        .res        (cmp_res)
    );

    assign hit     = pend_reg && (cmp_res.eq || cmp_res.gt);
    assign ptr_dec = ptr_reg - 1'b1;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        dst_next    = dst_reg;
        pend_next   = 1'b0;
        done_next   = 1'b0;
        op_next     = op_reg;
        rsp_next    = rsp_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = ptr_reg[AW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = dst_reg;
        mem_wr_data = mem_rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = req;
                    ptr_next = '0;
                    unique case (req.req_type)
                        REQ_ADD:
                        begin
                            if (count_reg == CW'(TABLE_DEPTH))
                            begin
                                done_next = 1'b1;
                                rsp_next  = make_rsp(ST_FULL, '0, count_reg);
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        REQ_DEL:
                        begin
                            if (IW'(req.entry_index) >= IW'(count_reg))
                            begin
                                done_next = 1'b1;
                                rsp_next  = make_rsp(ST_BADIDX, '0, count_reg);
                            end
                            else
                            begin
                                pos_next   = CW'(req.entry_index);
                                ptr_next   = CW'(req.entry_index) + 1'b1;
                                state_next = S_DEL;
                            end
                        end
                        REQ_FIND:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            // unused code: no change, plain ok result
                            done_next = 1'b1;
                            rsp_next  = make_rsp(ST_OK, '0, count_reg);
                        end
                    endcase
                end
            end

            // ascending walk: stop at first entry equal to or above the key
            S_SCAN:
            begin
                if (ptr_reg < count_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ptr_reg[AW-1:0];
                    dst_next    = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                if (hit)
                begin
                    pend_next = 1'b0;
                    if (op_reg.req_type == REQ_ADD)
                    begin
                        if (cmp_res.eq)
                        begin
                            done_next  = 1'b1;
                            rsp_next   = make_rsp(ST_DUP, '0, count_reg);
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            pos_next   = CW'(dst_reg);
                            ptr_next   = count_reg;
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                        if (cmp_res.eq)
                        begin
                            rsp_next = make_rsp(ST_OK, CW'(dst_reg), count_reg);
                        end
                        else
                        begin
                            rsp_next = make_rsp(ST_NOTFOUND, '0, count_reg);
                        end
                    end
                end
                else if (ptr_reg >= count_reg)
                begin
                    pend_next = 1'b0;
                    if (op_reg.req_type == REQ_ADD)
                    begin
                        // key above all entries: append
                        pos_next   = count_reg;
                        ptr_next   = count_reg;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        rsp_next   = make_rsp(ST_NOTFOUND, '0, count_reg);
                        state_next = S_IDLE;
                    end
                end
            end

            // move entries up one slot, top first, then place the new one
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = dst_reg;
                end
                if (ptr_reg > pos_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ptr_dec[AW-1:0];
                    dst_next    = ptr_reg[AW-1:0];
                    ptr_next    = ptr_dec;
                    pend_next   = 1'b1;
                end
                else if (!pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pos_reg[AW-1:0];
                    mem_wr_data = {op_reg.name_tag[NW-1:0], op_reg.freq_value};
                    count_next  = count_reg + 1'b1;
                    done_next   = 1'b1;
                    rsp_next    = make_rsp(ST_OK, pos_reg, count_reg + 1'b1);
                    state_next  = S_IDLE;
                end
            end

            // move later entries down one slot
            S_DEL:
            begin
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = dst_reg;
                end
                if (ptr_reg < count_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ptr_reg[AW-1:0];
                    dst_next    = ptr_dec[AW-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - 1'b1;
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(ST_OK, pos_reg, count_reg - 1'b1);
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        pos_reg <= pos_next;
        dst_reg <= dst_next;
        op_reg  <= op_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    // entry count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // the store is only written while a request is being worked
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> busy)
        else $error("entry store written while idle");

    // a full refusal is only reported with the table at depth
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_FULL) |-> (count_reg == CW'(TABLE_DEPTH)))
        else $error("full status with free slots");
`endif

endmodule

// ===== tb/sorted_station_table_core_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// sorted_station_table_core_test
// Drives add, delete and find request beats into the sorted station table and
// checks every result beat against a shadow copy of the table kept in the
// bench. Stimulus is a directed opener, then random segments that fill the
// table to full, drain it and mix lookups in, with random start gaps.
// ============================================================================
module sorted_station_table_core_test;
    import sst_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int NAME_BYTES  = NAME_BYTES_DEF;
    localparam logic [63:0] TAG_KEEP = (NAME_BYTES >= 8) ? {64{1'b1}} :
                                       ((64'd1 << (8 * NAME_BYTES)) - 64'd1);
    // request code with no operation behind it
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int RANDOM_BEATS = 750;
    localparam int CALM_TAIL    = 100;
    localparam int DRAIN_WAIT   = 100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_CAP   = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    // request beats still to be offered, results still owed by the block
    req_t req_backlog[$];
    rsp_t awaited_results[$];

    // shadow copy of the station table
    logic [31:0] shadow_freq [TABLE_DEPTH];
    logic [63:0] shadow_name [TABLE_DEPTH];
    int shadow_count = 0;

    int beats_total = 0;
    int beats_sent = 0;
    int gap_left = 0;
    int calm_left = 0;
    int errors = 0;
    int cycle_count = 0;

    sorted_station_table_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // slot of the entry holding hz, -1 when absent
    function automatic int slot_of(input logic [31:0] hz);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_freq[i] == hz)
                return i;
        end
        return -1;
    endfunction

    // apply one accepted request to the shadow table, queue its result
    task automatic station_predict(input req_t r);
        rsp_t e;
        int hit;
        int i;
        e.status = ST_OK;
        e.result_index = '0;
        hit = slot_of(r.freq_value);
        case (r.req_type)
            REQ_ADD:
            begin
                if (shadow_count >= TABLE_DEPTH)
                    e.status = ST_FULL;
                else if (hit >= 0)
                    e.status = ST_DUP;
                else
                begin
                    i = shadow_count;
                    while (i > 0 && shadow_freq[i-1] > r.freq_value)
                    begin
                        shadow_freq[i] = shadow_freq[i-1];
                        shadow_name[i] = shadow_name[i-1];
                        i--;
                    end
                    shadow_freq[i] = r.freq_value;
                    shadow_name[i] = r.name_tag & TAG_KEEP;
                    shadow_count++;
                    e.result_index = i[5:0];
                end
            end
            REQ_DEL:
            begin
                if (r.entry_index >= shadow_count)
                    e.status = ST_BADIDX;
                else
                begin
                    for (i = r.entry_index; i + 1 < shadow_count; i++)
                    begin
                        shadow_freq[i] = shadow_freq[i+1];
                        shadow_name[i] = shadow_name[i+1];
                    end
                    shadow_count--;
                    e.result_index = r.entry_index;
                end
            end
            REQ_FIND:
            begin
                if (hit < 0)
                    e.status = ST_NOTFOUND;
                else
                    e.result_index = hit[5:0];
            end
            default:
            begin
                // unused code: nothing changes
            end
        endcase
        e.entry_count = shadow_count[6:0];
        awaited_results.push_back(e);
    endtask

    task automatic queue_req(input logic [1:0] kind, input logic [31:0] hz,
                             input logic [63:0] tag, input logic [5:0] idx);
        req_t r;
        r.req_type = kind;
        r.freq_value = hz;
        r.name_tag = tag;
        r.entry_index = idx;
        req_backlog.push_back(r);
    endtask

    task automatic note_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        errors++;
        if (errors <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // driver: offer beats from the backlog, predict each one at acceptance
    always @(posedge clk)
    begin : beat_driver
        logic taken;
        if (rst_n)
        begin
            taken = start && !busy;
            if (taken)
            begin
                station_predict(req);
                beats_sent++;
                if (beats_sent < beats_total - CALM_TAIL)
                begin
                    if (calm_left > 0)
                        calm_left--;
                    else if ($urandom_range(0, 9) == 0)
                        calm_left = $urandom_range(10, 40);
                    else if ($urandom_range(0, 2) == 0)
                        gap_left = $urandom_range(1, 8);
                end
            end
            if (taken || !start)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (req_backlog.size() > 0)
                begin
                    start <= 1'b1;
                    req <= req_backlog.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: every done beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, rsp);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (rsp.status !== want.status)
                    note_mismatch("status", 8'(want.status), 8'(rsp.status));
                if (rsp.result_index !== want.result_index)
                    note_mismatch("result_index", 8'(want.result_index),
                                  8'(rsp.result_index));
                if (rsp.entry_count !== want.entry_count)
                    note_mismatch("entry_count", 8'(want.entry_count),
                                  8'(rsp.entry_count));
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_station_table_core_test: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [31:0] known_freq[$];
        logic [31:0] hz;
        logic [1:0] kind;
        logic [5:0] idx;
        int seg;
        int k;
        int roll;
        int sel;
        int add_pct;
        int del_pct;
        int made;

        // directed opener: empty table, extremes, refusals, edge slots
        queue_req(REQ_FIND, 32'h0, 64'h0, 6'd0);
        queue_req(REQ_DEL, 32'h0, 64'h0, 6'd0);
        queue_req(REQ_UNUSED, 32'hFFFF_FFFF, {64{1'b1}}, 6'd63);
        queue_req(REQ_ADD, 32'hFFFF_FFFF, 64'h0, 6'd0);
        queue_req(REQ_ADD, 32'h0, {64{1'b1}}, 6'd63);
        queue_req(REQ_ADD, 32'h0, 64'h1234_5678_9ABC_DEF0, 6'd0);
        queue_req(REQ_ADD, 32'h8000_0000, 64'hA5A5_5A5A_C3C3_3C3C, 6'd21);
        queue_req(REQ_ADD, 32'h7FFF_FFFF, 64'h0F0F_F0F0_0123_4567, 6'd42);
        queue_req(REQ_FIND, 32'hFFFF_FFFF, 64'h0, 6'd0);
        queue_req(REQ_FIND, 32'h0, {64{1'b1}}, 6'd63);
        queue_req(REQ_FIND, 32'h8000_0001, 64'h0, 6'd0);
        queue_req(REQ_DEL, 32'h0, 64'h0, 6'd63);
        queue_req(REQ_DEL, 32'h0, 64'h0, 6'd4);
        queue_req(REQ_DEL, 32'h0, 64'h0, 6'd3);
        queue_req(REQ_DEL, 32'h0, 64'h0, 6'd0);
        queue_req(REQ_FIND, 32'h8000_0000, 64'h0, 6'd0);
        queue_req(REQ_UNUSED, 32'h0, 64'h0, 6'd0);
        queue_req(REQ_ADD, 32'hFFFF_FFFF, 64'hFEDC_BA98_7654_3210, 6'd0);
        queue_req(REQ_DEL, 32'h0, 64'h0, 6'd1);
        queue_req(REQ_DEL, 32'h0, 64'h0, 6'd0);
        queue_req(REQ_DEL, 32'h0, 64'h0, 6'd0);
        queue_req(REQ_DEL, 32'h0, 64'h0, 6'd0);

        // random segments: fill to full, mix, drain, mix
        made = 0;
        seg = 0;
        while (made < RANDOM_BEATS)
        begin
            case (seg % 4)
                0:       begin add_pct = 88; del_pct = 6;  end
                2:       begin add_pct = 8;  del_pct = 85; end
                default: begin add_pct = 35; del_pct = 30; end
            endcase
            for (k = 0; k < 90 && made < RANDOM_BEATS; k++)
            begin
                roll = $urandom_range(0, 99);
                sel = $urandom_range(0, 9);
                idx = $urandom_range(0, 1) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 7));
                if (roll < 3)
                    kind = REQ_UNUSED;
                else if (roll < 3 + add_pct)
                    kind = REQ_ADD;
                else if (roll < 3 + add_pct + del_pct)
                    kind = REQ_DEL;
                else
                    kind = REQ_FIND;
                // frequency: a known one, an edge value or a fresh one
                if (known_freq.size() > 0 &&
                    sel < ((kind == REQ_FIND) ? 6 : 2))
                    hz = known_freq[$urandom_range(0, known_freq.size() - 1)];
                else if (sel < 7)
                    hz = $urandom;
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       hz = 32'h0;
                        1:       hz = 32'hFFFF_FFFF - $urandom_range(0, 3);
                        2:       hz = 32'h8000_0000 + $urandom_range(0, 3);
                        default: hz = $urandom_range(0, 31);
                    endcase
                end
                if (kind == REQ_ADD)
                begin
                    known_freq.push_back(hz);
                    if (known_freq.size() > 96)
                        void'(known_freq.pop_front());
                end
                queue_req(kind, hz, {$urandom, $urandom}, idx);
                made++;
            end
            seg++;
        end
        beats_total = req_backlog.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_sent < beats_total || awaited_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("sorted_station_table_core_test: done, clean");
        else
            $display("sorted_station_table_core_test: done, errors");
        $finish;
    end

endmodule
